// ----- hw/rtl/bpcs_pkg.sv -----
// ----------------------------------------------------------------------------
// bpcs_pkg
// Shared types and constants for the battery pack cell statistics block.
// ----------------------------------------------------------------------------
package bpcs_pkg;

	localparam int unsigned MV_W        = 16;
	localparam int unsigned CV_W        = 16;
	localparam int unsigned POS_W       = 5;
	localparam int unsigned TEMP_W      = 12;
	localparam int unsigned TEMP2_W     = 13;
	localparam int unsigned CNT_W       = 3;
	localparam int unsigned IDX_W       = 8;
	localparam int unsigned IDX_WIDE_W  = 9;
	localparam int unsigned PACK_TOT_W  = 19;
	localparam int unsigned PACK_MIN_W  = 13;
	localparam int unsigned AVG_W       = 15;
	localparam int unsigned IN_DATA_W   = 96;
	localparam int unsigned OUT_DATA_W  = 152;

	// Average by reciprocal multiply: floor(total * 10 / cells) is exact for
	// 19-bit totals and up to 256 cells with this shift.
	localparam int unsigned AVG_SHIFT   = 27;
	localparam int unsigned AVG_RECIP_W = 31;
	localparam int unsigned AVG_PROD_W  = PACK_TOT_W + AVG_RECIP_W;

	typedef logic signed [TEMP_W-1:0]  temp_t;
	typedef logic signed [TEMP2_W-1:0] temp2_t;

	localparam temp_t                   TEMP_MAX_INIT = -12'sd1000;
	localparam temp_t                   TEMP_MIN_INIT = 12'sd2000;
	localparam logic [PACK_MIN_W-1:0]   VMIN_INIT     = 13'd5000;

	// Input word, last-declared field in the lowest bits.
	typedef struct packed {
		logic [3:0]       pad;
		logic [POS_W-1:0] min_temp_cell;
		logic [POS_W-1:0] max_temp_cell;
		temp_t            temp_min_dc;
		temp_t            temp_max_dc;
		logic [POS_W-1:0] min_volt_cell;
		logic [POS_W-1:0] max_volt_cell;
		logic [CV_W-1:0]  module_total_cv;
		logic [MV_W-1:0]  cell_min_mv;
		logic [MV_W-1:0]  cell_max_mv;
	} in_item_t;

	// Result word, last-declared field in the lowest bits.
	typedef struct packed {
		logic [6:0]            pad;
		logic [IDX_W-1:0]      min_temp_index;
		logic [IDX_W-1:0]      max_temp_index;
		temp2_t                temp_spread;
		temp2_t                temp_sum;
		temp_t                 min_temp_adj;
		temp_t                 max_temp_adj;
		logic [IDX_W-1:0]      min_volt_index;
		logic [IDX_W-1:0]      max_volt_index;
		logic [AVG_W-1:0]      avg_cell_mv;
		logic [PACK_MIN_W-1:0] pack_min_mv;
		logic [MV_W-1:0]       pack_max_mv;
		logic [PACK_TOT_W-1:0] pack_total_cv;
	} out_item_t;

	// Subtract the fixed offset of each 5-degree band; low end included.
	function automatic temp_t band_correct(input temp_t t);
		temp_t r;
		r = t;
		if (t >= 12'sd200 && t < 12'sd250) begin
			r = t - 12'sd42;
		end else if (t >= 12'sd250 && t < 12'sd300) begin
			r = t - 12'sd47;
		end else if (t >= 12'sd300 && t < 12'sd350) begin
			r = t - 12'sd38;
		end else if (t >= 12'sd350 && t < 12'sd500) begin
			r = t - 12'sd47;
		end else if (t >= 12'sd500 && t < 12'sd550) begin
			r = t - 12'sd48;
		end else if (t >= 12'sd550 && t < 12'sd650) begin
			r = t - 12'sd60;
		end
		return r;
	endfunction

endpackage

// ----- hw/rtl/battery_pack_cell_statistics.sv -----
// ----------------------------------------------------------------------------
// battery_pack_cell_statistics
// Collects one report per battery module and emits the pack statistics.
// ----------------------------------------------------------------------------
// Feed one word per module, in module order 0 .. MODULES-1. Each word carries
// the module's voltage extremes, its total and its temperature extremes with
// the cell positions. The block takes one module word per clock while the
// output does not stall. Nothing comes out until the word of the last module,
// which passes the input register, the pack register and the result register
// before one result word leaves, and the block starts over on the next pack.
// On a tie the earlier module keeps a voltage extreme and the later module
// takes a temperature extreme. Temperatures are in 0.1 degree and are
// corrected per 5-degree band only at the output; the average is the pack
// total times ten over the cell count, found by a reciprocal multiply in the
// result stage.
// ----------------------------------------------------------------------------
module battery_pack_cell_statistics
	import bpcs_pkg::*;
#(
	parameter int unsigned MODULES          = 7,
	parameter int unsigned CELLS_PER_MODULE = 24
) (
	input  logic                  clk,
	input  logic                  arst_n,

	input  logic                  s_tvalid,
	output logic                  s_tready,
	// cell_max_mv, cell_min_mv, module_total_cv, max_volt_cell, min_volt_cell,
	// temp_max_dc, temp_min_dc, max_temp_cell, min_temp_cell, zero fill
	input  logic [IN_DATA_W-1:0]  s_tdata,

	output logic                  m_tvalid,
	input  logic                  m_tready,
	// pack_total_cv, pack_max_mv, pack_min_mv, avg_cell_mv, max_volt_index,
	// min_volt_index, max_temp_adj, min_temp_adj, temp_sum, temp_spread,
	// max_temp_index, min_temp_index, zero fill
	output logic [OUT_DATA_W-1:0] m_tdata
);

	localparam longint unsigned CELLS_TOTAL = longint'(MODULES) * longint'(CELLS_PER_MODULE);
	localparam longint unsigned AVG_RECIP_L =
		((64'd10 << AVG_SHIFT) + CELLS_TOTAL - 64'd1) / CELLS_TOTAL;
	localparam logic [AVG_RECIP_W-1:0] AVG_RECIP = AVG_RECIP_W'(AVG_RECIP_L);
	localparam logic [CNT_W-1:0]       LAST_MOD  = CNT_W'(MODULES - 1);
	localparam logic [IDX_WIDE_W-1:0]  CPM       = IDX_WIDE_W'(CELLS_PER_MODULE);
	localparam logic [POS_W:0]         CPM_POS   = (POS_W + 1)'(CELLS_PER_MODULE);

	// ---------------- handshake chain ----------------
	logic ready1, ready2, ready3;
	logic valid_s1, valid_s2, valid_s3;
	logic adv1;

	assign ready3   = !valid_s3 || m_tready;
	assign ready2   = !valid_s2 || ready3;
	assign ready1   = !valid_s1 || ready2;
	assign adv1     = valid_s1 && ready2;
	assign s_tready = ready1;
	assign m_tvalid = valid_s3;

	// ---------------- input register ----------------
	in_item_t in_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (ready1) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (ready1 && s_tvalid) begin
			in_s1 <= in_item_t'(s_tdata);
		end
	end

	// ---------------- running pack registers ----------------
	logic [CNT_W-1:0]      cnt_q;
	logic [PACK_TOT_W-1:0] total_q;
	logic [MV_W-1:0]       vmax_q;
	logic [PACK_MIN_W-1:0] vmin_q;
	logic [IDX_W-1:0]      vmax_idx_q, vmin_idx_q;
	temp_t                 tmax_q, tmin_q;
	logic [IDX_W-1:0]      tmax_idx_q, tmin_idx_q;

	logic                  first, last;
	logic [IDX_WIDE_W-1:0] vrow, trow;
	logic [POS_W-1:0]      tmax_pos, tmin_pos;
	logic [IDX_W-1:0]      vmax_cand, vmin_cand, tmax_cand, tmin_cand;
	logic                  vmax_upd, vmin_upd, tmax_upd, tmin_upd;
	logic [PACK_MIN_W-1:0] vmin_base;
	temp_t                 tmax_base, tmin_base;

	logic [PACK_TOT_W-1:0] total_nx;
	logic [MV_W-1:0]       vmax_nx;
	logic [PACK_MIN_W-1:0] vmin_nx;
	logic [IDX_W-1:0]      vmax_idx_nx, vmin_idx_nx;
	temp_t                 tmax_nx, tmin_nx;
	logic [IDX_W-1:0]      tmax_idx_nx, tmin_idx_nx;

	// A count of zero marks a fresh pack: the stored extremes are ignored and
	// the start values take their place, so no clearing is needed.
	assign first = (cnt_q == '0);
	assign last  = (cnt_q == LAST_MOD);

	// Cell indices: voltage rows start one module late, temperature is one-based.
	assign vrow = (IDX_WIDE_W'(cnt_q) + IDX_WIDE_W'(1)) * CPM;
	assign trow = IDX_WIDE_W'(cnt_q) * CPM;

	// Treat a temperature position past the module as cell 0.
	assign tmax_pos = ({1'b0, in_s1.max_temp_cell} >= CPM_POS) ? '0 : in_s1.max_temp_cell;
	assign tmin_pos = ({1'b0, in_s1.min_temp_cell} >= CPM_POS) ? '0 : in_s1.min_temp_cell;

	always_comb begin
		vmax_cand = IDX_W'(vrow + IDX_WIDE_W'(in_s1.max_volt_cell));
		vmin_cand = IDX_W'(vrow + IDX_WIDE_W'(in_s1.min_volt_cell));
		tmax_cand = IDX_W'(trow + IDX_WIDE_W'(tmax_pos) + IDX_WIDE_W'(1));
		tmin_cand = IDX_W'(trow + IDX_WIDE_W'(tmin_pos) + IDX_WIDE_W'(1));

		total_nx  = (first ? '0 : total_q) + PACK_TOT_W'(in_s1.module_total_cv);

		// Voltage: strict compares, earlier module keeps a tie.
		vmax_upd  = first || (in_s1.cell_max_mv > vmax_q);
		vmax_nx   = vmax_upd ? in_s1.cell_max_mv : vmax_q;
		vmax_idx_nx = vmax_upd ? vmax_cand : vmax_idx_q;

		vmin_base = first ? VMIN_INIT : vmin_q;
		vmin_upd  = (in_s1.cell_min_mv < MV_W'(vmin_base));
		vmin_nx   = vmin_upd ? PACK_MIN_W'(in_s1.cell_min_mv) : vmin_base;
		vmin_idx_nx = vmin_upd ? vmin_cand : (first ? '0 : vmin_idx_q);

		// Temperature: inclusive compares, later module takes a tie. The
		// index always comes from module 0 at the start of a pack.
		tmax_base = first ? TEMP_MAX_INIT : tmax_q;
		tmax_upd  = (tmax_base <= in_s1.temp_max_dc);
		tmax_nx   = tmax_upd ? in_s1.temp_max_dc : tmax_base;
		tmax_idx_nx = (tmax_upd || first) ? tmax_cand : tmax_idx_q;

		tmin_base = first ? TEMP_MIN_INIT : tmin_q;
		tmin_upd  = (tmin_base >= in_s1.temp_min_dc);
		tmin_nx   = tmin_upd ? in_s1.temp_min_dc : tmin_base;
		tmin_idx_nx = (tmin_upd || first) ? tmin_cand : tmin_idx_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (adv1) begin
			cnt_q <= last ? '0 : cnt_q + CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (adv1) begin
			total_q    <= total_nx;
			vmax_q     <= vmax_nx;
			vmin_q     <= vmin_nx;
			vmax_idx_q <= vmax_idx_nx;
			vmin_idx_q <= vmin_idx_nx;
			tmax_q     <= tmax_nx;
			tmin_q     <= tmin_nx;
			tmax_idx_q <= tmax_idx_nx;
			tmin_idx_q <= tmin_idx_nx;
		end
	end

	// ---------------- pack register: hold the finished pack ----------------
	logic [PACK_TOT_W-1:0] total_s2;
	logic [MV_W-1:0]       vmax_s2;
	logic [PACK_MIN_W-1:0] vmin_s2;
	logic [IDX_W-1:0]      vmax_idx_s2, vmin_idx_s2;
	temp_t                 tmax_s2, tmin_s2;
	logic [IDX_W-1:0]      tmax_idx_s2, tmin_idx_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (ready2) begin
			valid_s2 <= valid_s1 && last;
		end
	end

	always_ff @(posedge clk) begin
		if (adv1 && last) begin
			total_s2    <= total_nx;
			vmax_s2     <= vmax_nx;
			vmin_s2     <= vmin_nx;
			vmax_idx_s2 <= vmax_idx_nx;
			vmin_idx_s2 <= vmin_idx_nx;
			tmax_s2     <= tmax_nx;
			tmin_s2     <= tmin_nx;
			tmax_idx_s2 <= tmax_idx_nx;
			tmin_idx_s2 <= tmin_idx_nx;
		end
	end

	// ---------------- result register ----------------
	temp_t                 tmax_adj, tmin_adj;
	logic [AVG_PROD_W-1:0] avg_prod;
	out_item_t             res;
	out_item_t             out_s3;

	always_comb begin
		tmax_adj = band_correct(tmax_s2);
		tmin_adj = band_correct(tmin_s2);
		avg_prod = AVG_PROD_W'(total_s2) * AVG_PROD_W'(AVG_RECIP);

		res                = '0;
		res.pack_total_cv  = total_s2;
		res.pack_max_mv    = vmax_s2;
		res.pack_min_mv    = vmin_s2;
		res.avg_cell_mv    = avg_prod[AVG_SHIFT +: AVG_W];
		res.max_volt_index = vmax_idx_s2;
		res.min_volt_index = vmin_idx_s2;
		res.max_temp_adj   = tmax_adj;
		res.min_temp_adj   = tmin_adj;
		res.temp_sum       = TEMP2_W'(tmax_adj) + TEMP2_W'(tmin_adj);
		res.temp_spread    = TEMP2_W'(tmax_adj) - TEMP2_W'(tmin_adj);
		res.max_temp_index = tmax_idx_s2;
		res.min_temp_index = tmin_idx_s2;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (ready3) begin
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (ready3 && valid_s2) begin
			out_s3 <= res;
		end
	end

	assign m_tdata = OUT_DATA_W'(out_s3);

endmodule

// ----- test/battery_pack_cell_statistics_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// battery_pack_cell_statistics_tb
// Self-checking bench for the pack statistics block. Module words go in on
// the slave stream and pack results come back on the master stream. Both
// sides idle at random. A short directed table runs first: an all-zero pack,
// a pack at the field extremes, a pack where no temperature beats its start
// value, and a pack of ties and band edges; about ninety random packs follow.
// Each result is checked field by field against typed-in or bench-model stats.
// ----------------------------------------------------------------------------
module battery_pack_cell_statistics_tb;
	import bpcs_pkg::*;

	localparam int N_MODULES     = 7;
	localparam int CELLS_PER_MOD = 24;
	localparam int N_CELLS       = N_MODULES * CELLS_PER_MOD;
	localparam int RANDOM_PACKS  = 89;
	localparam int DRAIN_PACK    = 40;
	localparam int CYCLE_LIMIT   = 400000;

	// Flavors of random pack content.
	typedef enum int {
		STYLE_TYPICAL,
		STYLE_RAW,
		STYLE_TIES,
		STYLE_BANDS
	} pack_style_t;

	// One row of the directed table; want holds a typed-in result when typed is set.
	typedef struct {
		in_item_t  item;
		bit        typed;
		out_item_t want;
	} dir_row_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	// cell_max_mv, cell_min_mv, module_total_cv, max_volt_cell, min_volt_cell,
	// temp_max_dc, temp_min_dc, max_temp_cell, min_temp_cell, zero fill
	logic [IN_DATA_W-1:0]  s_tdata = '0;
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	// pack_total_cv, pack_max_mv, pack_min_mv, avg_cell_mv, max_volt_index,
	// min_volt_index, max_temp_adj, min_temp_adj, temp_sum, temp_spread,
	// max_temp_index, min_temp_index, zero fill
	logic [OUT_DATA_W-1:0] m_tdata;

	// Pack accumulator as the bench sees it.
	logic [CNT_W-1:0]      acc_module;
	logic [PACK_TOT_W-1:0] acc_total;
	int                    acc_hi_mv;
	int                    acc_lo_mv;
	logic [IDX_W-1:0]      acc_hi_mv_at;
	logic [IDX_W-1:0]      acc_lo_mv_at;
	int                    acc_hi_temp;
	int                    acc_lo_temp;
	logic [IDX_W-1:0]      acc_hi_temp_at;
	logic [IDX_W-1:0]      acc_lo_temp_at;

	out_item_t pending_stats[$];
	int        error_count = 0;
	int        cycle_count = 0;
	bit        no_idle = 1'b0;
	int        sink_hold = 0;

	battery_pack_cell_statistics #(
		.MODULES          (N_MODULES),
		.CELLS_PER_MODULE (CELLS_PER_MOD)
	) uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Idle length: mostly none, sometimes a few cycles, rarely a long stretch.
	function automatic int pick_gap();
		int roll;
		roll = $urandom_range(0, 99);
		if (no_idle) begin
			return 0;
		end
		if (roll < 55) begin
			return 0;
		end else if (roll < 85) begin
			return $urandom_range(1, 2);
		end else if (roll < 97) begin
			return $urandom_range(3, 6);
		end
		return $urandom_range(10, 40);
	endfunction

	// Start a fresh pack: voltage maximum open, voltage minimum and temperatures at their start values.
	function automatic void clear_pack();
		acc_module     = '0;
		acc_total      = '0;
		acc_hi_mv      = -1;
		acc_lo_mv      = 5000;
		acc_hi_mv_at   = '0;
		acc_lo_mv_at   = '0;
		acc_hi_temp    = -1000;
		acc_lo_temp    = 2000;
		acc_hi_temp_at = '0;
		acc_lo_temp_at = '0;
	endfunction

	// Subtract the fixed offset of each 5-degree band, low end included.
	function automatic int band_adjust(int t);
		if (t < 200 || t >= 650) begin
			return t;
		end
		case ((t - 200) / 50)
			0:       return t - 42;
			2:       return t - 38;
			6:       return t - 48;
			7, 8:    return t - 60;
			default: return t - 47;
		endcase
	endfunction

	// Fold one module word into the pack; return 1 with the stats after the last module.
	function automatic bit fold_module(input in_item_t w, output out_item_t stats);
		int m;
		int vmax;
		int vmin;
		int tmax;
		int tmin;
		int tmax_pos;
		int tmin_pos;
		int amax;
		int amin;
		int sum;
		int spread;
		int avg;
		int idx;
		bit up_max;
		bit up_min;
		m    = int'(acc_module);
		vmax = int'(w.cell_max_mv);
		vmin = int'(w.cell_min_mv);
		tmax = int'($signed(w.temp_max_dc));
		tmin = int'($signed(w.temp_min_dc));
		// Clamp temperature positions past the last cell to zero.
		tmax_pos = (int'(w.max_temp_cell) >= CELLS_PER_MOD) ? 0 : int'(w.max_temp_cell);
		tmin_pos = (int'(w.min_temp_cell) >= CELLS_PER_MOD) ? 0 : int'(w.min_temp_cell);
		stats = '0;

		acc_total = acc_total + PACK_TOT_W'(w.module_total_cv);

		// Voltage: strict compares, earlier module keeps a tie.
		if (vmax > acc_hi_mv) begin
			acc_hi_mv    = vmax;
			idx          = (m + 1) * CELLS_PER_MOD + int'(w.max_volt_cell);
			acc_hi_mv_at = idx[IDX_W-1:0];
		end
		if (vmin < acc_lo_mv) begin
			acc_lo_mv    = vmin;
			idx          = (m + 1) * CELLS_PER_MOD + int'(w.min_volt_cell);
			acc_lo_mv_at = idx[IDX_W-1:0];
		end

		// Temperature: later module takes a tie; module 0 always sets the index.
		up_max = (acc_hi_temp <= tmax);
		up_min = (acc_lo_temp >= tmin);
		if (up_max || m == 0) begin
			idx            = m * CELLS_PER_MOD + tmax_pos + 1;
			acc_hi_temp_at = idx[IDX_W-1:0];
		end
		if (up_max) begin
			acc_hi_temp = tmax;
		end
		if (up_min || m == 0) begin
			idx            = m * CELLS_PER_MOD + tmin_pos + 1;
			acc_lo_temp_at = idx[IDX_W-1:0];
		end
		if (up_min) begin
			acc_lo_temp = tmin;
		end

		if (m + 1 < N_MODULES) begin
			acc_module = acc_module + 1'b1;
			return 1'b0;
		end

		amax   = band_adjust(acc_hi_temp);
		amin   = band_adjust(acc_lo_temp);
		sum    = amax + amin;
		spread = amax - amin;
		avg    = (int'(acc_total) * 10) / N_CELLS;
		stats.pack_total_cv  = acc_total;
		stats.pack_max_mv    = acc_hi_mv[MV_W-1:0];
		stats.pack_min_mv    = acc_lo_mv[PACK_MIN_W-1:0];
		stats.avg_cell_mv    = avg[AVG_W-1:0];
		stats.max_volt_index = acc_hi_mv_at;
		stats.min_volt_index = acc_lo_mv_at;
		stats.max_temp_adj   = amax[TEMP_W-1:0];
		stats.min_temp_adj   = amin[TEMP_W-1:0];
		stats.temp_sum       = sum[TEMP2_W-1:0];
		stats.temp_spread    = spread[TEMP2_W-1:0];
		stats.max_temp_index = acc_hi_temp_at;
		stats.min_temp_index = acc_lo_temp_at;
		clear_pack();
		return 1'b1;
	endfunction

	function automatic in_item_t mk_item(int vmax, int vmin, int tot, int vmc, int vnc,
			int tmax, int tmin, int tmc, int tnc);
		in_item_t w;
		w = '0;
		w.cell_max_mv     = vmax[MV_W-1:0];
		w.cell_min_mv     = vmin[MV_W-1:0];
		w.module_total_cv = tot[CV_W-1:0];
		w.max_volt_cell   = vmc[POS_W-1:0];
		w.min_volt_cell   = vnc[POS_W-1:0];
		w.temp_max_dc     = tmax[TEMP_W-1:0];
		w.temp_min_dc     = tmin[TEMP_W-1:0];
		w.max_temp_cell   = tmc[POS_W-1:0];
		w.min_temp_cell   = tnc[POS_W-1:0];
		return w;
	endfunction

	function automatic out_item_t mk_stats(int tot, int vmax, int vmin, int avg, int vmax_at,
			int vmin_at, int amax, int amin, int sum, int spread, int tmax_at, int tmin_at);
		out_item_t s;
		s = '0;
		s.pack_total_cv  = tot[PACK_TOT_W-1:0];
		s.pack_max_mv    = vmax[MV_W-1:0];
		s.pack_min_mv    = vmin[PACK_MIN_W-1:0];
		s.avg_cell_mv    = avg[AVG_W-1:0];
		s.max_volt_index = vmax_at[IDX_W-1:0];
		s.min_volt_index = vmin_at[IDX_W-1:0];
		s.max_temp_adj   = amax[TEMP_W-1:0];
		s.min_temp_adj   = amin[TEMP_W-1:0];
		s.temp_sum       = sum[TEMP2_W-1:0];
		s.temp_spread    = spread[TEMP2_W-1:0];
		s.max_temp_index = tmax_at[IDX_W-1:0];
		s.min_temp_index = tmin_at[IDX_W-1:0];
		return s;
	endfunction

	// Random module word; the style steers values toward ties, band edges or raw bits.
	function automatic in_item_t rand_item(pack_style_t style);
		int edges [25];
		int vmax;
		int vmin;
		int tot;
		int tmax;
		int tmin;
		edges = '{199, 200, 201, 249, 250, 299, 300, 349, 350, 399, 400, 449, 450,
			499, 500, 549, 550, 599, 600, 649, 650, -1000, 2000, -1001, 2001};
		vmin = $urandom_range(2800, 4100);
		vmax = vmin + $urandom_range(0, 400);
		tot  = $urandom_range(7000, 10000);
		tmin = $urandom_range(0, 1000) - 200;
		tmax = tmin + $urandom_range(0, 150);
		case (style)
			STYLE_RAW: begin
				vmax = $urandom_range(0, 65535);
				vmin = $urandom_range(0, 65535);
				tot  = $urandom_range(0, 65535);
				tmax = $urandom_range(0, 4095);
				tmin = $urandom_range(0, 4095);
			end
			STYLE_TIES: begin
				vmax = 4000 + $urandom_range(0, 1);
				vmin = 4999 + $urandom_range(0, 2);
				tmax = 300 + $urandom_range(0, 1);
				tmin = 100 + $urandom_range(0, 1);
			end
			STYLE_BANDS: begin
				tmax = edges[$urandom_range(0, 24)];
				tmin = edges[$urandom_range(0, 24)];
			end
			default: begin
			end
		endcase
		return mk_item(vmax, vmin, tot, $urandom_range(0, 31), $urandom_range(0, 31),
			tmax, tmin, $urandom_range(0, 31), $urandom_range(0, 31));
	endfunction

	// Offer one module word after a random gap; return at the edge that takes it.
	task automatic send_word(input in_item_t w);
		int gap;
		gap = pick_gap();
		@(negedge clk);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= IN_DATA_W'(w);
		do begin
			@(posedge clk);
		end while (!s_tready);
	endtask

	// Hold off the sender until every pending result has left the block.
	task automatic wait_idle();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (pending_stats.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic check_field(input string name, input longint want, input longint got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			error_count++;
		end
	endtask

	// Sink: drop ready for random stretches, change it only at the falling edge.
	always @(negedge clk) begin
		if (sink_hold > 0) begin
			m_tready <= 1'b0;
			sink_hold = sink_hold - 1;
		end else begin
			m_tready <= 1'b1;
			sink_hold = pick_gap();
		end
	end

	// Compare every accepted result word with the oldest pending pack stats.
	always @(posedge clk) begin
		out_item_t got;
		out_item_t want;
		if (arst_n && m_tvalid && m_tready) begin
			got = out_item_t'(m_tdata);
			if (pending_stats.size() == 0) begin
				$error("result word with no pack pending");
				error_count++;
			end else begin
				want = pending_stats.pop_front();
				check_field("pack_total_cv", want.pack_total_cv, got.pack_total_cv);
				check_field("pack_max_mv", want.pack_max_mv, got.pack_max_mv);
				check_field("pack_min_mv", want.pack_min_mv, got.pack_min_mv);
				check_field("avg_cell_mv", want.avg_cell_mv, got.avg_cell_mv);
				check_field("max_volt_index", want.max_volt_index, got.max_volt_index);
				check_field("min_volt_index", want.min_volt_index, got.min_volt_index);
				check_field("max_temp_adj", $signed(want.max_temp_adj),
					$signed(got.max_temp_adj));
				check_field("min_temp_adj", $signed(want.min_temp_adj),
					$signed(got.min_temp_adj));
				check_field("temp_sum", $signed(want.temp_sum), $signed(got.temp_sum));
				check_field("temp_spread", $signed(want.temp_spread),
					$signed(got.temp_spread));
				check_field("max_temp_index", want.max_temp_index, got.max_temp_index);
				check_field("min_temp_index", want.min_temp_index, got.min_temp_index);
			end
		end
	end

	// Watchdog: a hung handshake ends the run as a failure.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	initial begin
		dir_row_t    rows[$];
		dir_row_t    row;
		out_item_t   stats;
		pack_style_t style;
		int          m;

		clear_pack();

		// All-zero pack: module 0 takes the voltage extremes, module 6 the temperatures.
		for (m = 0; m < N_MODULES; m++) begin
			row.item  = mk_item(0, 0, 0, 0, 0, 0, 0, 0, 0);
			row.typed = (m == N_MODULES - 1);
			row.want  = mk_stats(0, 0, 0, 0, 24, 24, 0, 0, 0, 0, 145, 145);
			rows.push_back(row);
		end
		// Field extremes: full totals, no voltage below 5000, clamped temp positions.
		for (m = 0; m < N_MODULES; m++) begin
			row.item  = mk_item(65535, 65535, 65535, 31, 31, 1500, -500, 31, 31);
			row.typed = (m == N_MODULES - 1);
			row.want  = mk_stats(458745, 65535, 5000, 27306, 55, 0, 1500, -500,
				1000, 2000, 145, 145);
			rows.push_back(row);
		end
		// No temperature beats its start value: index comes from module 0.
		for (m = 0; m < N_MODULES; m++) begin
			row.item  = mk_item(4000, 3000, 400, 0, 0, -2048, 2047, 5, 23);
			row.typed = (m == N_MODULES - 1);
			row.want  = mk_stats(2800, 4000, 3000, 166, 24, 24, -1000, 2000,
				1000, -3000, 6, 24);
			rows.push_back(row);
		end
		// Ties, band edges and the signed field limits, checked by the model.
		row.typed = 1'b0;
		row.want  = '0;
		row.item = mk_item(4100, 3200, 2800, 3, 4, 250, 199, 10, 24); rows.push_back(row);
		row.item = mk_item(4100, 3200, 2800, 9, 9, 250, 199, 23, 0);  rows.push_back(row);
		row.item = mk_item(0, 4999, 0, 1, 2, 200, 649, 1, 2);         rows.push_back(row);
		row.item = mk_item(65535, 0, 65535, 31, 31, 649, 650, 30, 25); rows.push_back(row);
		row.item = mk_item(5000, 5000, 1, 17, 17, 2047, -2048, 7, 7); rows.push_back(row);
		row.item = mk_item(65535, 0, 12345, 0, 0, 2047, -2048, 0, 0); rows.push_back(row);
		row.item = mk_item(3700, 3600, 9000, 12, 13, 500, 300, 4, 5); rows.push_back(row);

		arst_n = 1'b0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		foreach (rows[i]) begin
			send_word(rows[i].item);
			if (fold_module(rows[i].item, stats)) begin
				pending_stats.push_back(rows[i].typed ? rows[i].want : stats);
			end
		end

		for (int p = 0; p < RANDOM_PACKS; p++) begin
			style   = pack_style_t'($urandom_range(0, 3));
			no_idle = ($urandom_range(0, 9) == 0);
			if (p == DRAIN_PACK) begin
				wait_idle();
			end
			for (m = 0; m < N_MODULES; m++) begin
				row.item = rand_item(style);
				send_word(row.item);
				if (fold_module(row.item, stats)) begin
					pending_stats.push_back(stats);
				end
			end
		end
		no_idle = 1'b0;

		// Drain: let the last packs out, then allow a few cycles for strays.
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (pending_stats.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);

		if (error_count == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule
